// ===== src/wrp_pkg.sv =====
package wrp_pkg;

    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [3:0] RIFF_LEN = 4'd12;
    localparam logic [3:0] HEAD_LEN = 4'd8;
    localparam logic [3:0] FMT_CH_IDX   = 4'd3;
    localparam logic [3:0] FMT_RATE_IDX = 4'd7;
    localparam logic [3:0] FMT_BITS_IDX = 4'd15;
    localparam logic [32:0] FMT_USED = 33'd16;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_MISSING    = 2'd2;

    typedef enum logic [5:0] {
        PH_RIFF = 6'b000001,
        PH_HEAD = 6'b000010,
        PH_FMT  = 6'b000100,
        PH_SKIP = 6'b001000,
        PH_DONE = 6'b010000,
        PH_BAD  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [31:0] data_start;
        logic [31:0] data_length;
        logic [15:0] sample_bits;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [1:0]  status;
    } result_t;

    // Expected byte of the 12-byte file header; size bytes are not checked.
    function automatic logic [7:0] riff_expect(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h52;
            4'd1:    b = 8'h49;
            4'd2:    b = 8'h46;
            4'd3:    b = 8'h46;
            4'd8:    b = 8'h57;
            4'd9:    b = 8'h41;
            4'd10:   b = 8'h56;
            4'd11:   b = 8'h45;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic riff_checked(input logic [3:0] idx);
        return (idx < 4'd4) || ((idx >= 4'd8) && (idx < RIFF_LEN));
    endfunction

endpackage

// ===== src/wav_riff_header_parser.sv =====
// RIFF/WAVE header parser. Feed the file one byte per beat on s_axis; a beat
// with tuser set marks the end of the file and re-arms the parser. One result
// beat comes out on m_axis as soon as both the fmt and data chunk headers are
// seen (status ok), or at the end marker if that never happened (status bad
// header or chunk missing, other fields zero). Each beat is held in the input
// register; while the output slot is free or being drained, the parse state is
// updated and any result is loaded into the output register at the same edge,
// so a new beat can be taken every cycle while the result side keeps up.
module wav_riff_header_parser
    import wrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] end_marker
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] channel_count, [47:16] sample_rate, [63:48] sample_bits,
    // [95:64] data_length, [127:96] data_start
    output logic [127:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser    // [1:0] status
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;

    logic       adv;
    logic       res_valid;
    result_t    res;

    // Advance the held beat whenever the output slot is free or being drained.
    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;

    wrp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (adv),
        .data_byte  (in_byte_reg),
        .end_marker (in_end_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (adv)
                in_valid_reg <= 1'b0;

            if (adv && res_valid)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tuser;
        end
        if (adv && res_valid)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {out_res_reg.data_start, out_res_reg.data_length,
                            out_res_reg.sample_bits, out_res_reg.sample_rate,
                            out_res_reg.channel_count};

endmodule

// ===== src/wrp_parse.sv =====
module wrp_parse
    import wrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       end_marker,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [3:0]  idx_reg, idx_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [32:0] skip_reg, skip_next;
    logic [31:0] fmt_reg, fmt_next;
    logic        got_fmt_reg, got_fmt_next;
    logic        got_data_reg, got_data_next;
    logic [15:0] ch_reg, ch_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] dlen_reg, dlen_next;
    logic [31:0] dstart_reg, dstart_next;

    logic [3:0]  idx_inc;
    logic [32:0] padded;
    logic [32:0] skip_dec;

    assign idx_inc = idx_reg + 4'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        hdr_ok_next   = hdr_ok_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        skip_next     = skip_reg;
        fmt_next      = fmt_reg;
        got_fmt_next  = got_fmt_reg;
        got_data_next = got_data_reg;
        ch_next       = ch_reg;
        rate_next     = rate_reg;
        bits_next     = bits_reg;
        dlen_next     = dlen_reg;
        dstart_next   = dstart_reg;
        padded        = '0;
        skip_dec      = skip_reg - 33'd1;
        res_valid     = 1'b0;
        res           = '0;

        if (end_marker)
        begin
            // Report failure unless already done, then re-arm for the next file.
            if (phase_reg != PH_DONE)
            begin
                res_valid  = 1'b1;
                res.status = ((phase_reg == PH_RIFF) || (phase_reg == PH_BAD)) ?
                             ST_BAD_HEADER : ST_MISSING;
            end
            phase_next    = PH_RIFF;
            pos_next      = '0;
            idx_next      = '0;
            hdr_ok_next   = 1'b1;
            tag_next      = '0;
            len_next      = '0;
            skip_next     = '0;
            fmt_next      = '0;
            got_fmt_next  = 1'b0;
            got_data_next = 1'b0;
            ch_next       = '0;
            rate_next     = '0;
            bits_next     = '0;
            dlen_next     = '0;
            dstart_next   = '0;
        end
        else
        begin
            pos_next = pos_reg + 32'd1;
            case (phase_reg)
                PH_RIFF:
                begin
                    if (riff_checked(idx_reg) && (data_byte != riff_expect(idx_reg)))
                        hdr_ok_next = 1'b0;
                    idx_next = idx_inc;
                    if (idx_inc >= RIFF_LEN)
                    begin
                        idx_next   = '0;
                        phase_next = hdr_ok_next ? PH_HEAD : PH_BAD;
                    end
                end
                PH_HEAD:
                begin
                    if (idx_reg < 4'd4)
                        tag_next = {tag_reg[23:0], data_byte};
                    else
                        len_next = {data_byte, len_reg[31:8]};
                    idx_next = idx_inc;
                    if (idx_inc >= HEAD_LEN)
                    begin
                        idx_next = '0;
                        padded   = {1'b0, len_next} + {32'd0, len_next[0]};
                        if ((tag_next == TAG_FMT) && (|len_next[31:4]))
                        begin
                            fmt_next   = '0;
                            phase_next = PH_FMT;
                        end
                        else
                        begin
                            skip_next  = padded;
                            phase_next = (|padded) ? PH_SKIP : PH_HEAD;
                            if (tag_next == TAG_DATA)
                            begin
                                dlen_next     = len_next;
                                dstart_next   = pos_reg + 32'd1;
                                got_data_next = 1'b1;
                                if (got_fmt_reg)
                                begin
                                    phase_next = PH_DONE;
                                    res_valid  = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_FMT:
                begin
                    fmt_next = {data_byte, fmt_reg[31:8]};
                    if (idx_reg == FMT_CH_IDX)
                        ch_next = fmt_next[31:16];
                    else if (idx_reg == FMT_RATE_IDX)
                        rate_next = fmt_next;
                    else if (idx_reg == FMT_BITS_IDX)
                        bits_next = fmt_next[31:16];
                    idx_next = idx_inc;
                    if (idx_inc == 4'd0)
                    begin
                        got_fmt_next = 1'b1;
                        padded       = {1'b0, len_reg} + {32'd0, len_reg[0]} - FMT_USED;
                        skip_next    = padded;
                        phase_next   = (|padded) ? PH_SKIP : PH_HEAD;
                        if (got_data_reg)
                        begin
                            phase_next = PH_DONE;
                            res_valid  = 1'b1;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (|skip_reg)
                        skip_next = skip_dec;
                    if (skip_next == '0)
                        phase_next = PH_HEAD;
                end
                default:
                begin
                end
            endcase
            if (res_valid)
            begin
                res.status        = ST_OK;
                res.channel_count = ch_next;
                res.sample_rate   = rate_next;
                res.sample_bits   = bits_next;
                res.data_length   = dlen_next;
                res.data_start    = dstart_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RIFF;
            pos_reg      <= '0;
            idx_reg      <= '0;
            hdr_ok_reg   <= 1'b1;
            tag_reg      <= '0;
            len_reg      <= '0;
            skip_reg     <= '0;
            fmt_reg      <= '0;
            got_fmt_reg  <= 1'b0;
            got_data_reg <= 1'b0;
            ch_reg       <= '0;
            rate_reg     <= '0;
            bits_reg     <= '0;
            dlen_reg     <= '0;
            dstart_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            idx_reg      <= idx_next;
            hdr_ok_reg   <= hdr_ok_next;
            tag_reg      <= tag_next;
            len_reg      <= len_next;
            skip_reg     <= skip_next;
            fmt_reg      <= fmt_next;
            got_fmt_reg  <= got_fmt_next;
            got_data_reg <= got_data_next;
            ch_reg       <= ch_next;
            rate_reg     <= rate_next;
            bits_reg     <= bits_next;
            dlen_reg     <= dlen_next;
            dstart_reg   <= dstart_next;
        end
    end

endmodule
